// ----- rtl/sfp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types and constants for the streaming first-position substring search.
// ----------------------------------------------------------------------------
package sfp_pkg;

  localparam int MAX_PATTERN  = 16;
  localparam int WINDOW_DEPTH = MAX_PATTERN - 1;
  localparam int LEN_W        = 5;
  localparam int POS_W        = 16;
  localparam int COUNT_W      = POS_W + 1;
  localparam int CFG_INDEX_W  = 4;
  localparam int CFG_DATA_W   = 64;

  localparam logic [COUNT_W-1:0] MAX_TEXT = COUNT_W'(1) << POS_W;
  localparam logic [LEN_W-1:0]   MAX_LEN  = LEN_W'(MAX_PATTERN);

  typedef logic [7:0] byte_t;
  typedef byte_t window_t [MAX_PATTERN];
  typedef logic [8*MAX_PATTERN-1:0] pattern_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW  = 4'd0,
    REG_PATTERN_HIGH = 4'd1,
    REG_PATTERN_LEN  = 4'd2,
    REG_START_OFFSET = 4'd3
  } cfg_reg_t;

endpackage

// ----- rtl/sfp_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_match
// Parallel comparison of the byte window, ending at the newest byte, with the
// first pattern_length bytes of the configured pattern.
// ----------------------------------------------------------------------------
module sfp_match (
  input  sfp_pkg::window_t                window,
  input  sfp_pkg::pattern_t               pattern,
  input  logic [sfp_pkg::LEN_W-1:0]       pattern_length,
  output logic [sfp_pkg::LEN_W-1:0]       length_used,
  output logic                            same
);

  logic [sfp_pkg::MAX_PATTERN-1:0] equal;

  assign length_used = (pattern_length > sfp_pkg::MAX_LEN) ? sfp_pkg::MAX_LEN
                                                           : pattern_length;

  // Pattern byte k lines up with the window entry length_used - 1 - k.
  always_comb begin
    logic [sfp_pkg::LEN_W-1:0] idx;
    idx = '0;
    for (int k = 0; k < sfp_pkg::MAX_PATTERN; k++) begin
      idx = length_used - sfp_pkg::LEN_W'(1) - sfp_pkg::LEN_W'(k);
      if (sfp_pkg::LEN_W'(k) < length_used) begin
        equal[k] = (window[idx[sfp_pkg::LEN_W-2:0]] == pattern[8*k +: 8]);
      end else begin
        equal[k] = 1'b1;
      end
    end
  end

  assign same = &equal;

endmodule

// ----- rtl/substring_first_position_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_first_position_core
// Streaming search for the first occurrence of a configured byte pattern.
// ----------------------------------------------------------------------------
// Text bytes enter on the s_axis channel, one item per byte, with tlast on the
// final byte of each text. The user must write the pattern (up to 16 bytes),
// its length and the start offset through the cfg channel while the block is
// idle; the block does not enforce this. cfg_ready is always high and unknown
// indexes are ignored. For each text one item leaves on m_axis after its last
// byte: found and the absolute start position of the first occurrence at or
// after the offset. An input item is held in an input register, then compared
// with the pattern in parallel and folded into the running state; the result
// of a last byte is registered in the output register and leaves on m_axis.
// One byte is accepted every clock cycle while the output is not blocked.
// When the receiver stalls, the result waits in the output register and
// ordinary bytes still flow; only a further last byte waits in the input
// register until the output register is free.
// Texts longer than 65536 bytes saturate the byte count; later bytes cannot
// complete a match. Reset clears the config, window, valid flags and search state.
// ----------------------------------------------------------------------------
module substring_first_position_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sfp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sfp_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,   // text_byte
  input  logic                                s_axis_tlast,   // last_byte
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [23:0]                         m_axis_tdata    // found, match_position
);

  logic [63:0]                     pattern_low;
  logic [63:0]                     pattern_high;
  logic [sfp_pkg::LEN_W-1:0]       pattern_length;
  logic [sfp_pkg::POS_W-1:0]       start_offset;

  logic                            s1_valid;
  sfp_pkg::byte_t                  s1_byte;
  logic                            s1_last;
  logic                            s1_fire;

  sfp_pkg::byte_t                  recent [sfp_pkg::WINDOW_DEPTH];
  logic [sfp_pkg::COUNT_W-1:0]     bytes_seen;
  logic                            hit_latched;
  logic [sfp_pkg::POS_W-1:0]       hit_position;

  logic                            out_valid;
  logic                            out_found;
  logic [sfp_pkg::POS_W-1:0]       out_position;

  sfp_pkg::window_t                window;
  logic [sfp_pkg::LEN_W-1:0]       length_used;
  logic                            same;
  logic                            counting;
  logic [sfp_pkg::COUNT_W:0]       begin_wide;
  logic                            begin_ok;
  logic                            hit_now;
  logic [sfp_pkg::COUNT_W-1:0]     bytes_seen_next;
  logic                            hit_latched_next;
  logic [sfp_pkg::POS_W-1:0]       hit_position_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
      start_offset   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sfp_pkg::REG_PATTERN_LOW:  pattern_low    <= cfg_data;
        sfp_pkg::REG_PATTERN_HIGH: pattern_high   <= cfg_data;
        sfp_pkg::REG_PATTERN_LEN:  pattern_length <= cfg_data[sfp_pkg::LEN_W-1:0];
        sfp_pkg::REG_START_OFFSET: start_offset   <= cfg_data[sfp_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_fire       = s1_valid && (!s1_last || !out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_byte <= s_axis_tdata;
      s1_last <= s_axis_tlast;
    end
  end

  always_comb begin
    window[0] = s1_byte;
    for (int j = 1; j < sfp_pkg::MAX_PATTERN; j++) begin
      window[j] = recent[j-1];
    end
  end

  sfp_match u_match (
    .window         (window),
    .pattern        ({pattern_high, pattern_low}),
    .pattern_length (pattern_length),
    .length_used    (length_used),
    .same           (same)
  );

  assign counting   = (bytes_seen < sfp_pkg::MAX_TEXT);
  assign begin_wide = {1'b0, bytes_seen} + (sfp_pkg::COUNT_W+1)'(1)
                      - (sfp_pkg::COUNT_W+1)'(length_used);
  assign begin_ok   = !begin_wide[sfp_pkg::COUNT_W]
                      && (begin_wide[sfp_pkg::POS_W-1:0] >= start_offset);
  assign hit_now    = counting && (length_used != '0) && !hit_latched
                      && same && begin_ok;

  assign bytes_seen_next   = counting ? bytes_seen + sfp_pkg::COUNT_W'(1) : bytes_seen;
  assign hit_latched_next  = hit_latched || hit_now;
  assign hit_position_next = hit_now ? begin_wide[sfp_pkg::POS_W-1:0] : hit_position;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < sfp_pkg::WINDOW_DEPTH; j++) begin
        recent[j] <= '0;
      end
      bytes_seen   <= '0;
      hit_latched  <= 1'b0;
      hit_position <= '0;
    end else if (s1_fire) begin
      if (s1_last) begin
        for (int j = 0; j < sfp_pkg::WINDOW_DEPTH; j++) begin
          recent[j] <= '0;
        end
        bytes_seen   <= '0;
        hit_latched  <= 1'b0;
        hit_position <= '0;
      end else begin
        recent[0] <= s1_byte;
        for (int j = 1; j < sfp_pkg::WINDOW_DEPTH; j++) begin
          recent[j] <= recent[j-1];
        end
        bytes_seen   <= bytes_seen_next;
        hit_latched  <= hit_latched_next;
        hit_position <= hit_position_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      if (length_used == '0) begin
        out_found    <= ({1'b0, start_offset} < bytes_seen_next);
        out_position <= '0;
      end else begin
        out_found    <= hit_latched_next;
        out_position <= hit_latched_next ? hit_position_next : '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, out_position, out_found};

endmodule
